@@ rtl/core/mtep_pkg.sv @@
package mtep_pkg;

    localparam int VLQ_MAX_BYTES = 4;
    localparam int VLQ_SEEN_W    = 3;
    localparam int VLQ_W         = 28;

    localparam logic [7:0] DATA_MASK      = 8'h7F;
    localparam logic [7:0] STATUS_BIT     = 8'h80;
    localparam logic [7:0] SYS_MASK       = 8'hF0;
    localparam logic [7:0] STAT_META      = 8'hFF;
    localparam logic [7:0] STAT_SYSEX     = 8'hF0;
    localparam logic [7:0] STAT_SYSEX_ESC = 8'hF7;
    localparam logic [7:0] META_TEMPO     = 8'h51;
    localparam logic [7:0] META_END       = 8'h2F;
    localparam logic [7:0] KIND_NOTE_OFF  = 8'h80;
    localparam logic [7:0] KIND_NOTE_ON   = 8'h90;
    localparam logic [7:0] KIND_PROGRAM   = 8'hC0;
    localparam logic [7:0] KIND_PRESSURE  = 8'hD0;
    localparam logic [7:0] CHAN_MASK      = 8'h0F;
    localparam logic [VLQ_W-1:0] TEMPO_LEN = VLQ_W'(3);

    typedef enum logic [3:0] {
        PH_DELTA      = 4'd0,
        PH_STATUS     = 4'd1,
        PH_DATA1      = 4'd2,
        PH_DATA2      = 4'd3,
        PH_META_TYPE  = 4'd4,
        PH_META_LEN   = 4'd5,
        PH_META_BODY  = 4'd6,
        PH_SYSEX_LEN  = 4'd7,
        PH_SYSEX_BODY = 4'd8,
        PH_DEAD       = 4'd9
    } phase_t;

    typedef enum logic [2:0] {
        EV_NOTE_OFF = 3'd0,
        EV_NOTE_ON  = 3'd1,
        EV_PROGRAM  = 3'd2,
        EV_TEMPO    = 3'd3,
        EV_END      = 3'd4,
        EV_ERROR    = 3'd5
    } event_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE        = 2'd0,
        ERR_MALFORMED   = 2'd1,
        ERR_OVERFLOW    = 2'd2,
        ERR_UNSUPPORTED = 2'd3
    } error_code_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_of_track;
        logic [15:0] track_number;
    } in_beat_t;

    typedef struct packed {
        event_kind_t event_kind;
        error_code_t error_code;
        logic [63:0] abs_tick;
        logic [15:0] track_id;
        logic [3:0]  midi_channel;
        logic [6:0]  note_or_program;
        logic [6:0]  note_velocity;
        logic [23:0] tempo_usec;
        logic [31:0] seq_number;
        logic        track_done;
    } out_beat_t;

    // Program change and channel pressure carry one data byte, the rest two.
    function automatic logic two_data(input logic [7:0] status);
        logic [7:0] kind;
        kind = status & SYS_MASK;
        return (kind != KIND_PROGRAM) && (kind != KIND_PRESSURE);
    endfunction

endpackage

@@ rtl/core/midi_track_event_parser.sv @@
// Channel | Ports                       | Beat
// input   | s_valid s_ready s_beat      | one track byte, last flag, track number
// output  | m_valid m_ready m_beat      | one parsed event, error or track end
//
// One byte per cycle while results are taken; a byte is parsed out of the input
// register and its event, if any, is written to the result register with m_valid high.
// Most bytes give no event; at most one event per byte.
// aresetn (synchronous, active low) clears the parse state and sequence count.
// A held result stalls the parse stage; the input register still takes one byte.
module midi_track_event_parser
    import mtep_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_beat,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_beat
);

    in_beat_t  in_reg;
    logic      in_valid_reg;
    out_beat_t out_reg;
    logic      out_valid_reg;

    phase_t                  phase_reg,  phase_step;
    logic [63:0]             tick_reg,   tick_step;
    logic [VLQ_W-1:0]        vlq_reg,    vlq_step;
    logic [VLQ_SEEN_W-1:0]   seen_reg,   seen_step;
    logic [7:0]              run_reg,    run_step;
    logic [7:0]              cur_reg,    cur_step;
    logic [6:0]              first_reg,  first_step;
    logic [7:0]              meta_reg,   meta_step;
    logic [VLQ_W-1:0]        left_reg,   left_step;
    logic [23:0]             tempo_reg,  tempo_step;
    logic [31:0]             seq_reg,    seq_next;

    logic                    advance;
    logic                    fire;
    logic [7:0]              b;
    logic                    last;
    logic [VLQ_W-1:0]        vlq_shift;
    logic [VLQ_SEEN_W-1:0]   seen_inc;
    logic                    vlq_end;
    logic                    vlq_long;
    logic [64:0]             tick_sum;
    logic [7:0]              st;
    logic                    chan_fin;
    logic                    meta_fin;
    logic                    dead;
    logic [6:0]              d2;
    logic                    res_have;
    event_kind_t             res_kind;
    error_code_t             res_err;
    out_beat_t               res;

    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_beat  = out_reg;

    assign b         = in_reg.data_byte;
    assign last      = in_reg.last_of_track;
    assign vlq_shift = {vlq_reg[VLQ_W-8:0], b[6:0]};
    assign seen_inc  = seen_reg + VLQ_SEEN_W'(1);
    assign vlq_end   = !b[7];
    assign vlq_long  = b[7] && (seen_inc >= VLQ_SEEN_W'(VLQ_MAX_BYTES));
    assign tick_sum  = {1'b0, tick_reg} + {37'd0, vlq_shift};
    assign st        = b[7] ? b : run_reg;

    // Per-byte state step and result selection
    always_comb begin
        phase_step = phase_reg;
        tick_step  = tick_reg;
        vlq_step   = vlq_reg;
        seen_step  = seen_reg;
        run_step   = run_reg;
        cur_step   = cur_reg;
        first_step = first_reg;
        meta_step  = meta_reg;
        left_step  = left_reg;
        tempo_step = tempo_reg;
        res_have   = 1'b0;
        res_kind   = EV_NOTE_OFF;
        res_err    = ERR_NONE;
        d2         = '0;
        chan_fin   = 1'b0;
        meta_fin   = 1'b0;
        dead       = 1'b0;

        unique case (phase_reg)
            PH_DELTA: begin
                vlq_step  = vlq_shift;
                seen_step = seen_inc;
                if (vlq_end) begin
                    vlq_step  = '0;
                    seen_step = '0;
                    if (tick_sum[64]) begin
                        res_have   = 1'b1;
                        res_kind   = EV_ERROR;
                        res_err    = ERR_OVERFLOW;
                        phase_step = PH_DEAD;
                    end else begin
                        tick_step  = tick_sum[63:0];
                        phase_step = PH_STATUS;
                    end
                end else if (vlq_long) begin
                    res_have   = 1'b1;
                    res_kind   = EV_ERROR;
                    res_err    = ERR_MALFORMED;
                    phase_step = PH_DEAD;
                end
            end
            PH_STATUS: begin
                if (!b[7] && (!run_reg[7] || ((run_reg & SYS_MASK) == SYS_MASK))) begin
                    res_have   = 1'b1;
                    res_kind   = EV_ERROR;
                    res_err    = ERR_MALFORMED;
                    phase_step = PH_DEAD;
                end else begin
                    if (!b[7]) begin
                        first_step = b[6:0];
                    end else if ((b & SYS_MASK) != SYS_MASK) begin
                        run_step = b;
                    end
                    if (st == STAT_META) begin
                        run_step   = '0;
                        phase_step = PH_META_TYPE;
                    end else if (st == STAT_SYSEX || st == STAT_SYSEX_ESC) begin
                        run_step   = '0;
                        phase_step = PH_SYSEX_LEN;
                    end else if ((st & SYS_MASK) == SYS_MASK) begin
                        res_have   = 1'b1;
                        res_kind   = EV_ERROR;
                        res_err    = ERR_UNSUPPORTED;
                        phase_step = PH_DEAD;
                    end else begin
                        cur_step = st;
                        if (b[7]) begin
                            phase_step = PH_DATA1;
                        end else if (two_data(st)) begin
                            phase_step = PH_DATA2;
                        end else begin
                            chan_fin = 1'b1;
                        end
                    end
                end
            end
            PH_DATA1: begin
                if (b[7]) begin
                    res_have   = 1'b1;
                    res_kind   = EV_ERROR;
                    res_err    = ERR_MALFORMED;
                    phase_step = PH_DEAD;
                end else begin
                    first_step = b[6:0];
                    if (two_data(cur_reg)) begin
                        phase_step = PH_DATA2;
                    end else begin
                        chan_fin = 1'b1;
                    end
                end
            end
            PH_DATA2: begin
                if (b[7]) begin
                    res_have   = 1'b1;
                    res_kind   = EV_ERROR;
                    res_err    = ERR_MALFORMED;
                    phase_step = PH_DEAD;
                end else begin
                    d2       = b[6:0];
                    chan_fin = 1'b1;
                end
            end
            PH_META_TYPE: begin
                meta_step  = b;
                phase_step = PH_META_LEN;
            end
            PH_META_LEN: begin
                vlq_step  = vlq_shift;
                seen_step = seen_inc;
                if (vlq_end) begin
                    vlq_step   = '0;
                    seen_step  = '0;
                    tempo_step = '0;
                    left_step  = vlq_shift;
                    // a tempo meta of the wrong length is skipped like any other
                    if (meta_reg == META_TEMPO && vlq_shift != TEMPO_LEN) begin
                        meta_step = '0;
                    end
                    if (vlq_shift == '0) begin
                        meta_fin = 1'b1;
                    end else begin
                        phase_step = PH_META_BODY;
                    end
                end else if (vlq_long) begin
                    res_have   = 1'b1;
                    res_kind   = EV_ERROR;
                    res_err    = ERR_MALFORMED;
                    phase_step = PH_DEAD;
                end
            end
            PH_META_BODY: begin
                tempo_step = {tempo_reg[15:0], b};
                left_step  = left_reg - VLQ_W'(1);
                if (left_reg == VLQ_W'(1)) begin
                    meta_fin = 1'b1;
                end
            end
            PH_SYSEX_LEN: begin
                vlq_step  = vlq_shift;
                seen_step = seen_inc;
                if (vlq_end) begin
                    vlq_step   = '0;
                    seen_step  = '0;
                    left_step  = vlq_shift;
                    phase_step = (vlq_shift == '0) ? PH_DELTA : PH_SYSEX_BODY;
                end else if (vlq_long) begin
                    res_have   = 1'b1;
                    res_kind   = EV_ERROR;
                    res_err    = ERR_MALFORMED;
                    phase_step = PH_DEAD;
                end
            end
            PH_SYSEX_BODY: begin
                left_step = left_reg - VLQ_W'(1);
                if (left_reg == VLQ_W'(1)) begin
                    phase_step = PH_DELTA;
                end
            end
            default: begin
                // drop everything until the final byte of the track
                dead = 1'b1;
            end
        endcase

        if (chan_fin) begin
            phase_step = PH_DELTA;
            if ((cur_step & SYS_MASK) == KIND_NOTE_OFF) begin
                res_have = 1'b1;
                res_kind = EV_NOTE_OFF;
            end else if ((cur_step & SYS_MASK) == KIND_NOTE_ON) begin
                res_have = 1'b1;
                res_kind = (d2 != '0) ? EV_NOTE_ON : EV_NOTE_OFF;
            end else if ((cur_step & SYS_MASK) == KIND_PROGRAM) begin
                res_have = 1'b1;
                res_kind = EV_PROGRAM;
            end
        end

        if (meta_fin) begin
            if (meta_step == META_TEMPO) begin
                res_have = 1'b1;
                if (tempo_step == '0) begin
                    res_kind   = EV_ERROR;
                    res_err    = ERR_MALFORMED;
                    phase_step = PH_DEAD;
                end else begin
                    res_kind   = EV_TEMPO;
                    phase_step = PH_DELTA;
                end
            end else if (meta_step == META_END) begin
                res_have   = 1'b1;
                res_kind   = EV_END;
                phase_step = PH_DEAD;
            end else begin
                phase_step = PH_DELTA;
            end
        end

        // final byte: close cleanly only between events
        if (last && !dead && !res_have) begin
            res_have = 1'b1;
            if (phase_step == PH_DELTA && seen_step == '0) begin
                res_kind = EV_END;
            end else begin
                res_kind = EV_ERROR;
                res_err  = ERR_MALFORMED;
            end
        end

        seq_next = seq_reg + 32'(res_have && (res_kind == EV_NOTE_OFF ||
                   res_kind == EV_NOTE_ON || res_kind == EV_PROGRAM ||
                   res_kind == EV_TEMPO));
    end

    // Result beat formatting
    always_comb begin
        res                 = '0;
        res.event_kind      = res_kind;
        res.error_code      = res_err;
        res.abs_tick        = tick_step;
        res.track_id        = in_reg.track_number;
        res.seq_number      = seq_reg;
        res.track_done      = last || res_kind == EV_END || res_kind == EV_ERROR;
        unique case (res_kind)
            EV_NOTE_OFF, EV_NOTE_ON: begin
                res.midi_channel    = 4'(cur_step & CHAN_MASK);
                res.note_or_program = first_step;
                res.note_velocity   = d2;
            end
            EV_PROGRAM: begin
                res.midi_channel    = 4'(cur_step & CHAN_MASK);
                res.note_or_program = first_step;
            end
            EV_TEMPO: begin
                res.tempo_usec = tempo_step;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= fire && res_have;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_beat;
        end
        if (fire && res_have) begin
            out_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_DELTA;
            tick_reg  <= '0;
            vlq_reg   <= '0;
            seen_reg  <= '0;
            run_reg   <= '0;
            cur_reg   <= '0;
            first_reg <= '0;
            meta_reg  <= '0;
            left_reg  <= '0;
            tempo_reg <= '0;
            seq_reg   <= '0;
        end else if (fire) begin
            seq_reg <= seq_next;
            if (last) begin
                // start the next track from a clean state
                phase_reg <= PH_DELTA;
                tick_reg  <= '0;
                vlq_reg   <= '0;
                seen_reg  <= '0;
                run_reg   <= '0;
                cur_reg   <= '0;
                first_reg <= '0;
                meta_reg  <= '0;
                left_reg  <= '0;
                tempo_reg <= '0;
            end else begin
                phase_reg <= phase_step;
                tick_reg  <= tick_step;
                vlq_reg   <= vlq_step;
                seen_reg  <= seen_step;
                run_reg   <= run_step;
                cur_reg   <= cur_step;
                first_reg <= first_step;
                meta_reg  <= meta_step;
                left_reg  <= left_step;
                tempo_reg <= tempo_step;
            end
        end
    end

endmodule
